[design/rvexc_pkg.sv]
// Shared types and constants for the RV32I execute and commit core.
package rvexc_pkg;

    localparam int unsigned MEM_WORDS_DEF = 1024;
    localparam int unsigned XLEN          = 32;
    localparam int unsigned REG_COUNT     = 32;
    localparam int unsigned REG_IDX_W     = 5;
    localparam int unsigned SHAMT_W       = 5;
    localparam int unsigned CMD_W         = 6;
    localparam int unsigned CNT_W         = 64;

    localparam logic [XLEN-1:0] PC_STEP   = 32'd4;
    localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFF_FFFE;

    // Operation codes of the decoded instruction; codes above AUIPC are unsupported.
    typedef enum logic [CMD_W-1:0] {
        CMD_NOP   = 6'd0,
        CMD_ADD   = 6'd1,
        CMD_SUB   = 6'd2,
        CMD_SLL   = 6'd3,
        CMD_SLT   = 6'd4,
        CMD_SLTU  = 6'd5,
        CMD_XOR   = 6'd6,
        CMD_SRL   = 6'd7,
        CMD_SRA   = 6'd8,
        CMD_OR    = 6'd9,
        CMD_AND   = 6'd10,
        CMD_ADDI  = 6'd11,
        CMD_SLTI  = 6'd12,
        CMD_SLTIU = 6'd13,
        CMD_XORI  = 6'd14,
        CMD_ORI   = 6'd15,
        CMD_ANDI  = 6'd16,
        CMD_SLLI  = 6'd17,
        CMD_SRLI  = 6'd18,
        CMD_SRAI  = 6'd19,
        CMD_LW    = 6'd20,
        CMD_SW    = 6'd21,
        CMD_BEQ   = 6'd22,
        CMD_BNE   = 6'd23,
        CMD_BLT   = 6'd24,
        CMD_BGE   = 6'd25,
        CMD_BLTU  = 6'd26,
        CMD_BGEU  = 6'd27,
        CMD_JAL   = 6'd28,
        CMD_JALR  = 6'd29,
        CMD_LUI   = 6'd30,
        CMD_AUIPC = 6'd31
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNSUP = 2'd1,
        ERR_MEM   = 2'd2
    } t_err;

endpackage

[design/rvexc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module rvexc_ram #(
    parameter  int unsigned WIDTH = 32,
    parameter  int unsigned DEPTH = 32,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the same edge as a write to the same entry returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/rv32i_execute_commit_core.sv]
// RV32I execute and commit core: one decoded instruction in, one commit record out.
// Throughput is one item per cycle while the commit channel is ready; an in-range word load
// first holds the execute stage to read the data memory, whose read port is registered.
// Each item is held in the input stage register, then in the result register that drives the
// commit record. Reset (synchronous, active low) zeroes PC, retire count and register valid
// bits, then clears MEM_WORDS data words.
module rv32i_execute_commit_core #(
    parameter int unsigned MEM_WORDS = rvexc_pkg::MEM_WORDS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Instruction channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [rvexc_pkg::CMD_W-1:0]           i_command,
    input  logic [rvexc_pkg::REG_IDX_W-1:0]       i_dest_index,
    input  logic [rvexc_pkg::REG_IDX_W-1:0]       i_src1_index,
    input  logic [rvexc_pkg::REG_IDX_W-1:0]       i_src2_index,
    input  logic signed [rvexc_pkg::XLEN-1:0]     i_imm_value,
    // Commit channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_commit_ok,
    output logic [rvexc_pkg::XLEN-1:0]            o_commit_pc,
    output logic                                  o_reg_written,
    output logic [rvexc_pkg::REG_IDX_W-1:0]       o_written_index,
    output logic [rvexc_pkg::XLEN-1:0]            o_written_value,
    output logic                                  o_store_done,
    output logic [rvexc_pkg::XLEN-1:0]            o_store_address,
    output logic [rvexc_pkg::XLEN-1:0]            o_store_data,
    output logic [rvexc_pkg::XLEN-1:0]            o_following_pc,
    output logic [1:0]                            o_error_code,
    output logic [rvexc_pkg::CNT_W-1:0]           o_retired_count
);

    import rvexc_pkg::*;

    localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    // ------------------------------------------------------------------
    // Control and architectural state.
    // ------------------------------------------------------------------
    logic                  r_clr_busy;     // data memory clearing pass after reset
    logic [AW-1:0]         r_clr_cnt;
    logic [XLEN-1:0]       r_pc;
    logic [CNT_W-1:0]      r_retire;
    logic [REG_COUNT-1:0]  r_rf_vld;       // register written since reset; x0 never set

    // Input stage: the accepted item plus the operand read context.
    logic                  r_in_vld;
    logic [CMD_W-1:0]      r_cmd;
    logic [REG_IDX_W-1:0]  r_rd;
    logic [REG_IDX_W-1:0]  r_rs1;
    logic [REG_IDX_W-1:0]  r_rs2;
    logic [XLEN-1:0]       r_imm;
    logic                  r_src1_ok;
    logic                  r_src2_ok;
    logic                  r_load_wait;    // load has issued its memory read

    // The register write committed at the same edge the held item was accepted.
    // The register file read at that edge returns the old word, so this bypasses it.
    logic                  r_byp_en;
    logic [REG_IDX_W-1:0]  r_byp_idx;
    logic [XLEN-1:0]       r_byp_val;

    // Result register.
    logic                  r_out_vld;
    logic                  r_out_ok;
    logic [XLEN-1:0]       r_out_pc;
    logic                  r_out_wr;
    logic [REG_IDX_W-1:0]  r_out_widx;
    logic [XLEN-1:0]       r_out_wval;
    logic                  r_out_st;
    logic [XLEN-1:0]       r_out_saddr;
    logic [XLEN-1:0]       r_out_sdata;
    logic [XLEN-1:0]       r_out_next;
    t_err                  r_out_err;
    logic [CNT_W-1:0]      r_out_cnt;

    // ------------------------------------------------------------------
    // Execute logic.
    // ------------------------------------------------------------------
    logic                  in_accept;
    logic                  exec_move;
    logic                  load_issue;
    logic [XLEN-1:0]       rf1_q;
    logic [XLEN-1:0]       rf2_q;
    logic [XLEN-1:0]       dm_q;
    logic [XLEN-1:0]       op_a;
    logic [XLEN-1:0]       op_b;
    logic [XLEN-1:0]       mem_addr;
    logic                  mem_in_range;
    logic [XLEN-1:0]       pc_plus4;
    logic [XLEN-1:0]       res;
    logic                  wr;
    logic                  st;
    logic                  taken;
    logic [XLEN-1:0]       next_pc;
    t_err                  err;
    logic                  ok;
    logic                  rf_wr;
    logic [CNT_W-1:0]      retire_inc;

    // Operand selection: bypass first, then the register file, zero if never written.
    assign op_a = (r_byp_en && (r_byp_idx == r_rs1)) ? r_byp_val :
                  (r_src1_ok ? rf1_q : '0);
    assign op_b = (r_byp_en && (r_byp_idx == r_rs2)) ? r_byp_val :
                  (r_src2_ok ? rf2_q : '0);

    // Load and store share one address adder; the two low bits are ignored.
    assign mem_addr     = op_a + r_imm;
    assign mem_in_range = (mem_addr[XLEN-1:2] < (XLEN-2)'(MEM_WORDS));
    assign pc_plus4     = r_pc + PC_STEP;

    always_comb begin
        res     = '0;
        wr      = 1'b0;
        st      = 1'b0;
        taken   = 1'b0;
        next_pc = pc_plus4;
        err     = ERR_NONE;
        unique case (r_cmd)
            CMD_NOP:   ;
            CMD_ADD:   begin res = op_a + op_b; wr = 1'b1; end
            CMD_SUB:   begin res = op_a - op_b; wr = 1'b1; end
            CMD_SLL:   begin res = op_a << op_b[SHAMT_W-1:0]; wr = 1'b1; end
            CMD_SLT:   begin res = XLEN'($signed(op_a) < $signed(op_b)); wr = 1'b1; end
            CMD_SLTU:  begin res = XLEN'(op_a < op_b); wr = 1'b1; end
            CMD_XOR:   begin res = op_a ^ op_b; wr = 1'b1; end
            CMD_SRL:   begin res = op_a >> op_b[SHAMT_W-1:0]; wr = 1'b1; end
            CMD_SRA:   begin
                res = XLEN'($signed(op_a) >>> op_b[SHAMT_W-1:0]);
                wr  = 1'b1;
            end
            CMD_OR:    begin res = op_a | op_b; wr = 1'b1; end
            CMD_AND:   begin res = op_a & op_b; wr = 1'b1; end
            CMD_ADDI:  begin res = op_a + r_imm; wr = 1'b1; end
            CMD_SLTI:  begin res = XLEN'($signed(op_a) < $signed(r_imm)); wr = 1'b1; end
            CMD_SLTIU: begin res = XLEN'(op_a < r_imm); wr = 1'b1; end
            CMD_XORI:  begin res = op_a ^ r_imm; wr = 1'b1; end
            CMD_ORI:   begin res = op_a | r_imm; wr = 1'b1; end
            CMD_ANDI:  begin res = op_a & r_imm; wr = 1'b1; end
            CMD_SLLI:  begin res = op_a << r_imm[SHAMT_W-1:0]; wr = 1'b1; end
            CMD_SRLI:  begin res = op_a >> r_imm[SHAMT_W-1:0]; wr = 1'b1; end
            CMD_SRAI:  begin
                res = XLEN'($signed(op_a) >>> r_imm[SHAMT_W-1:0]);
                wr  = 1'b1;
            end
            CMD_LW:    begin
                if (mem_in_range) begin
                    res = dm_q;
                    wr  = 1'b1;
                end else begin
                    err = ERR_MEM;
                end
            end
            CMD_SW:    begin
                if (mem_in_range) begin
                    st = 1'b1;
                end else begin
                    err = ERR_MEM;
                end
            end
            CMD_BEQ:   taken = (op_a == op_b);
            CMD_BNE:   taken = (op_a != op_b);
            CMD_BLT:   taken = ($signed(op_a) < $signed(op_b));
            CMD_BGE:   taken = !($signed(op_a) < $signed(op_b));
            CMD_BLTU:  taken = (op_a < op_b);
            CMD_BGEU:  taken = (op_a >= op_b);
            CMD_JAL:   begin res = pc_plus4; wr = 1'b1; next_pc = r_pc + r_imm; end
            CMD_JALR:  begin res = pc_plus4; wr = 1'b1; next_pc = mem_addr & JALR_MASK; end
            CMD_LUI:   begin res = r_imm; wr = 1'b1; end
            CMD_AUIPC: begin res = r_pc + r_imm; wr = 1'b1; end
            default:   err = ERR_UNSUP;
        endcase
        if (taken) begin
            next_pc = r_pc + r_imm;
        end
    end

    assign ok         = (err == ERR_NONE);
    assign rf_wr      = ok && wr && (r_rd != '0);
    assign retire_inc = r_retire + CNT_W'(1);

    // A load in range first reads the data memory before it can leave the execute stage.
    assign load_issue = r_in_vld && (r_cmd == CMD_LW) && mem_in_range && !r_load_wait;
    assign exec_move  = r_in_vld && !load_issue && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_clr_busy && (!r_in_vld || exec_move);
    assign in_accept  = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Memories. The register file is kept twice so both operands are read together.
    // ------------------------------------------------------------------
    rvexc_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (exec_move && rf_wr),
        .i_waddr (r_rd),
        .i_wdata (res),
        .i_re    (in_accept),
        .i_raddr (i_src1_index),
        .o_rdata (rf1_q)
    );

    rvexc_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (exec_move && rf_wr),
        .i_waddr (r_rd),
        .i_wdata (res),
        .i_re    (in_accept),
        .i_raddr (i_src2_index),
        .o_rdata (rf2_q)
    );

    logic            dm_we;
    logic [AW-1:0]   dm_waddr;
    logic [XLEN-1:0] dm_wdata;

    // The clearing pass owns the write port until it finishes; no item runs meanwhile.
    assign dm_we    = r_clr_busy || (exec_move && ok && st);
    assign dm_waddr = r_clr_busy ? r_clr_cnt : mem_addr[AW+1:2];
    assign dm_wdata = r_clr_busy ? '0 : op_b;

    rvexc_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (load_issue),
        .i_raddr (mem_addr[AW+1:2]),
        .o_rdata (dm_q)
    );

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
            r_pc        <= '0;
            r_retire    <= '0;
            r_rf_vld    <= '0;
            r_in_vld    <= 1'b0;
            r_load_wait <= 1'b0;
            r_byp_en    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(MEM_WORDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (load_issue) begin
                r_load_wait <= 1'b1;
            end else if (exec_move) begin
                r_load_wait <= 1'b0;
            end

            if (exec_move && ok) begin
                r_pc     <= next_pc;
                r_retire <= retire_inc;
            end
            if (exec_move && rf_wr) begin
                r_rf_vld[r_rd] <= 1'b1;
            end

            if (in_accept) begin
                r_in_vld <= 1'b1;
                r_byp_en <= exec_move && rf_wr;
            end else if (exec_move) begin
                r_in_vld <= 1'b0;
            end

            if (exec_move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd     <= i_command;
            r_rd      <= i_dest_index;
            r_rs1     <= i_src1_index;
            r_rs2     <= i_src2_index;
            r_imm     <= i_imm_value;
            r_src1_ok <= r_rf_vld[i_src1_index];
            r_src2_ok <= r_rf_vld[i_src2_index];
            r_byp_idx <= r_rd;
            r_byp_val <= res;
        end
        if (exec_move) begin
            r_out_ok    <= ok;
            r_out_pc    <= r_pc;
            r_out_wr    <= rf_wr;
            r_out_widx  <= rf_wr ? r_rd : '0;
            r_out_wval  <= rf_wr ? res : '0;
            r_out_st    <= ok && st;
            r_out_saddr <= (ok && st) ? mem_addr : '0;
            r_out_sdata <= (ok && st) ? op_b : '0;
            r_out_next  <= ok ? next_pc : r_pc;
            r_out_err   <= err;
            r_out_cnt   <= ok ? retire_inc : r_retire;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_commit_ok     = r_out_ok;
    assign o_commit_pc     = r_out_pc;
    assign o_reg_written   = r_out_wr;
    assign o_written_index = r_out_widx;
    assign o_written_value = r_out_wval;
    assign o_store_done    = r_out_st;
    assign o_store_address = r_out_saddr;
    assign o_store_data    = r_out_sdata;
    assign o_following_pc  = r_out_next;
    assign o_error_code    = r_out_err;
    assign o_retired_count = r_out_cnt;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_accept_while_clearing : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready
    ) else $error("item accepted during the memory clearing pass");

    a_load_wait_clears : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_load_wait && exec_move) |=> !r_load_wait
    ) else $error("load wait flag stayed set after the load left the execute stage");

    a_retire_counts_commits : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (exec_move && ok) |=> (r_retire == $past(r_retire) + CNT_W'(1))
    ) else $error("retire counter did not advance on a committed item");

    a_error_changes_nothing : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (exec_move && !ok) |=> (r_pc == $past(r_pc)) && (r_retire == $past(r_retire))
    ) else $error("faulting item changed PC or retire count");

    a_error_record_clean : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_ok) |->
            (!r_out_wr && !r_out_st && (r_out_next == r_out_pc))
    ) else $error("faulting commit record reports a side effect");

    a_no_x0_write : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (exec_move && rf_wr) |-> (r_rd != '0)
    ) else $error("register x0 written");

endmodule

[tb/sv/tb_rv32i_execute_commit_core.sv]
// Self-checking testbench for the RV32I execute and commit core.
module tb_rv32i_execute_commit_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rvexc_pkg::*;

    // The core is built at its default memory size; the architectural copy below matches it.
    localparam int unsigned MEM_DEPTH    = MEM_WORDS_DEF;
    localparam int unsigned MEM_AW       = $clog2(MEM_DEPTH);
    localparam int unsigned RANDOM_ITEMS = 1050;
    // Cycles with no handshake on either channel before the run is declared hung. The limit
    // is several times the clearing pass after reset, which writes each of the MEM_DEPTH words,
    // and well above the longest random gap on either side.
    localparam int unsigned STALL_LIMIT  = 5 * MEM_DEPTH;
    // Trailing cycles after the last commit record.
    localparam int unsigned DRAIN_CYCLES = 12;

    // Bounds of the unsupported operation codes.
    localparam logic [CMD_W-1:0] CMD_UNSUP_LO = 6'd32;
    localparam logic [CMD_W-1:0] CMD_UNSUP_HI = 6'd63;

    // One decoded instruction as it is presented on the instruction channel.
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [REG_IDX_W-1:0] rd;
        logic [REG_IDX_W-1:0] rs1;
        logic [REG_IDX_W-1:0] rs2;
        logic [XLEN-1:0]      imm;
    } t_instr;

    // One commit record, field for field as the core reports it.
    typedef struct packed {
        logic             ok;
        logic [XLEN-1:0]  pc;
        logic             wr;
        logic [REG_IDX_W-1:0] widx;
        logic [XLEN-1:0]  wval;
        logic             st;
        logic [XLEN-1:0]  saddr;
        logic [XLEN-1:0]  sdata;
        logic [XLEN-1:0]  npc;
        t_err             err;
        logic [CNT_W-1:0] count;
    } t_commit_rec;

    // Clock, reset and every block input start at known values.
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic [CMD_W-1:0]     i_command       = '0;
    logic [REG_IDX_W-1:0] i_dest_index    = '0;
    logic [REG_IDX_W-1:0] i_src1_index    = '0;
    logic [REG_IDX_W-1:0] i_src2_index    = '0;
    logic signed [XLEN-1:0] i_imm_value   = '0;
    logic                 i_out_ready     = 1'b0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_commit_ok;
    logic [XLEN-1:0]      o_commit_pc;
    logic                 o_reg_written;
    logic [REG_IDX_W-1:0] o_written_index;
    logic [XLEN-1:0]      o_written_value;
    logic                 o_store_done;
    logic [XLEN-1:0]      o_store_address;
    logic [XLEN-1:0]      o_store_data;
    logic [XLEN-1:0]      o_following_pc;
    logic [1:0]           o_error_code;
    logic [CNT_W-1:0]     o_retired_count;

    rv32i_execute_commit_core #(
        .MEM_WORDS(MEM_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_dest_index    (i_dest_index),
        .i_src1_index    (i_src1_index),
        .i_src2_index    (i_src2_index),
        .i_imm_value     (i_imm_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_commit_ok     (o_commit_ok),
        .o_commit_pc     (o_commit_pc),
        .o_reg_written   (o_reg_written),
        .o_written_index (o_written_index),
        .o_written_value (o_written_value),
        .o_store_done    (o_store_done),
        .o_store_address (o_store_address),
        .o_store_data    (o_store_data),
        .o_following_pc  (o_following_pc),
        .o_error_code    (o_error_code),
        .o_retired_count (o_retired_count)
    );

    // Architectural state as the core should hold it after every retired instruction.
    logic [XLEN-1:0]  arch_regs [REG_COUNT];
    logic [XLEN-1:0]  data_mem  [MEM_DEPTH];
    logic [XLEN-1:0]  arch_pc;
    logic [CNT_W-1:0] retire_cnt;

    t_instr      instr_pending [$];   // instructions not yet offered to the core
    t_commit_rec commit_expected [$]; // commit records owed by the core, oldest first
    int unsigned items_accepted = 0;
    int unsigned items_total    = 0;
    int unsigned mismatches     = 0;
    int unsigned in_gap_left    = 0;
    int unsigned in_calm_left   = 0;
    int unsigned out_stall_left = 0;
    int unsigned out_calm_left  = 0;
    int unsigned idle_cycles    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Executes one instruction against the architectural state and returns the commit
    // record it must produce. Errors leave every piece of state untouched.
    function automatic t_commit_rec retire_instr(t_instr ins);
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] res;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] next_pc;
        logic            wr;
        logic            st;
        logic            taken;
        t_err            err;
        t_commit_rec     rec;

        a       = (ins.rs1 == '0) ? '0 : arch_regs[ins.rs1];
        b       = (ins.rs2 == '0) ? '0 : arch_regs[ins.rs2];
        res     = '0;
        addr    = '0;
        next_pc = arch_pc + PC_STEP;
        wr      = 1'b0;
        st      = 1'b0;
        taken   = 1'b0;
        err     = ERR_NONE;
        case (ins.cmd)
            CMD_NOP:   ;
            CMD_ADD:   begin res = a + b; wr = 1'b1; end
            CMD_SUB:   begin res = a - b; wr = 1'b1; end
            CMD_SLL:   begin res = a << b[SHAMT_W-1:0]; wr = 1'b1; end
            CMD_SLT:   begin res = XLEN'($signed(a) < $signed(b)); wr = 1'b1; end
            CMD_SLTU:  begin res = XLEN'(a < b); wr = 1'b1; end
            CMD_XOR:   begin res = a ^ b; wr = 1'b1; end
            CMD_SRL:   begin res = a >> b[SHAMT_W-1:0]; wr = 1'b1; end
            CMD_SRA:   begin res = $signed(a) >>> b[SHAMT_W-1:0]; wr = 1'b1; end
            CMD_OR:    begin res = a | b; wr = 1'b1; end
            CMD_AND:   begin res = a & b; wr = 1'b1; end
            CMD_ADDI:  begin res = a + ins.imm; wr = 1'b1; end
            CMD_SLTI:  begin res = XLEN'($signed(a) < $signed(ins.imm)); wr = 1'b1; end
            CMD_SLTIU: begin res = XLEN'(a < ins.imm); wr = 1'b1; end
            CMD_XORI:  begin res = a ^ ins.imm; wr = 1'b1; end
            CMD_ORI:   begin res = a | ins.imm; wr = 1'b1; end
            CMD_ANDI:  begin res = a & ins.imm; wr = 1'b1; end
            CMD_SLLI:  begin res = a << ins.imm[SHAMT_W-1:0]; wr = 1'b1; end
            CMD_SRLI:  begin res = a >> ins.imm[SHAMT_W-1:0]; wr = 1'b1; end
            CMD_SRAI:  begin res = $signed(a) >>> ins.imm[SHAMT_W-1:0]; wr = 1'b1; end
            CMD_LW: begin
                // The two low address bits are dropped; only the word index matters.
                addr = a + ins.imm;
                if ((addr >> 2) >= MEM_DEPTH) begin
                    err = ERR_MEM;
                end else begin
                    res = data_mem[addr[MEM_AW+1:2]];
                    wr  = 1'b1;
                end
            end
            CMD_SW: begin
                addr = a + ins.imm;
                if ((addr >> 2) >= MEM_DEPTH) begin
                    err = ERR_MEM;
                end else begin
                    st = 1'b1;
                end
            end
            CMD_BEQ:   taken = (a == b);
            CMD_BNE:   taken = (a != b);
            CMD_BLT:   taken = ($signed(a) < $signed(b));
            CMD_BGE:   taken = !($signed(a) < $signed(b));
            CMD_BLTU:  taken = (a < b);
            CMD_BGEU:  taken = (a >= b);
            CMD_JAL: begin
                res = arch_pc + PC_STEP; wr = 1'b1; next_pc = arch_pc + ins.imm;
            end
            CMD_JALR: begin
                // The target uses the source as read before the link register is written.
                res = arch_pc + PC_STEP; wr = 1'b1; next_pc = (a + ins.imm) & JALR_MASK;
            end
            CMD_LUI:   begin res = ins.imm; wr = 1'b1; end
            CMD_AUIPC: begin res = arch_pc + ins.imm; wr = 1'b1; end
            default:   err = ERR_UNSUP;
        endcase

        rec     = '0;
        rec.pc  = arch_pc;
        rec.err = err;
        if (err != ERR_NONE) begin
            rec.npc   = arch_pc;
            rec.count = retire_cnt;
        end else begin
            if (taken) begin
                next_pc = arch_pc + ins.imm;
            end
            if (wr && ins.rd != '0) begin
                arch_regs[ins.rd] = res;
                rec.wr   = 1'b1;
                rec.widx = ins.rd;
                rec.wval = res;
            end
            if (st) begin
                data_mem[addr[MEM_AW+1:2]] = b;
                rec.st    = 1'b1;
                rec.saddr = addr;
                rec.sdata = b;
            end
            arch_pc    = next_pc;
            retire_cnt = retire_cnt + CNT_W'(1);
            rec.ok     = 1'b1;
            rec.npc    = next_pc;
            rec.count  = retire_cnt;
        end
        return rec;
    endfunction

    // Random gap length: mostly none or short, now and then long. A calm stretch of
    // back-to-back cycles starts now and then so that full-rate operation is covered too.
    function automatic int unsigned draw_gap(inout int unsigned calm_left);
        int unsigned roll;

        if (calm_left != 0) begin
            calm_left = calm_left - 1;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm_left = $urandom_range(16, 64);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Immediates lean toward the values that matter: extremes, small offsets, shift counts.
    function automatic logic [XLEN-1:0] pick_imm();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 4095) - 2048;
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0001;
                    default: return '0;
                endcase
            end
            2: return $urandom_range(0, 63);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_instr(logic [CMD_W-1:0] cmd, logic [REG_IDX_W-1:0] rd,
                               logic [REG_IDX_W-1:0] rs1, logic [REG_IDX_W-1:0] rs2,
                               logic [XLEN-1:0] imm);
        t_instr ins;

        ins.cmd = cmd;
        ins.rd  = rd;
        ins.rs1 = rs1;
        ins.rs2 = rs2;
        ins.imm = imm;
        instr_pending.push_back(ins);
    endtask

    // Instruction driver. An item offered stays put until the core takes it; the slot is
    // refilled at the same edge so that back-to-back items keep valid high throughout.
    always @(posedge i_clk) begin
        t_instr ins;

        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            in_gap_left <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                ins.cmd = i_command;
                ins.rd  = i_dest_index;
                ins.rs1 = i_src1_index;
                ins.rs2 = i_src2_index;
                ins.imm = i_imm_value;
                commit_expected.push_back(retire_instr(ins));
                items_accepted = items_accepted + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap_left != 0) begin
                    i_in_valid  <= 1'b0;
                    in_gap_left <= in_gap_left - 1;
                end else if (instr_pending.size() != 0) begin
                    ins = instr_pending.pop_front();
                    i_command    <= ins.cmd;
                    i_dest_index <= ins.rd;
                    i_src1_index <= ins.rs1;
                    i_src2_index <= ins.rs2;
                    i_imm_value  <= ins.imm;
                    i_in_valid   <= 1'b1;
                    in_gap_left  <= draw_gap(in_calm_left);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [CNT_W-1:0] expv,
                                        logic [CNT_W-1:0] actv);
        if (expv !== actv) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
            mismatches = mismatches + 1;
        end
    endfunction

    // Commit monitor. Every accepted record is matched against the oldest one owed, while
    // ready is stalled at random independently of what the core is doing.
    always @(posedge i_clk) begin
        t_commit_rec rec;

        if (!i_rst_n) begin
            i_out_ready    <= 1'b0;
            out_stall_left <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (commit_expected.size() == 0) begin
                    $error("commit item with no instruction outstanding, pc 0x%0h",
                           o_commit_pc);
                    mismatches = mismatches + 1;
                end else begin
                    rec = commit_expected.pop_front();
                    check_field("commit_ok", CNT_W'(rec.ok), CNT_W'(o_commit_ok));
                    check_field("commit_pc", CNT_W'(rec.pc), CNT_W'(o_commit_pc));
                    check_field("reg_written", CNT_W'(rec.wr), CNT_W'(o_reg_written));
                    check_field("written_index", CNT_W'(rec.widx),
                                CNT_W'(o_written_index));
                    check_field("written_value", CNT_W'(rec.wval),
                                CNT_W'(o_written_value));
                    check_field("store_done", CNT_W'(rec.st), CNT_W'(o_store_done));
                    check_field("store_address", CNT_W'(rec.saddr),
                                CNT_W'(o_store_address));
                    check_field("store_data", CNT_W'(rec.sdata), CNT_W'(o_store_data));
                    check_field("following_pc", CNT_W'(rec.npc), CNT_W'(o_following_pc));
                    check_field("error_code", CNT_W'(rec.err), CNT_W'(o_error_code));
                    check_field("retired_count", rec.count, o_retired_count);
                end
            end
            if (out_stall_left != 0) begin
                i_out_ready    <= 1'b0;
                out_stall_left <= out_stall_left - 1;
            end else begin
                i_out_ready    <= 1'b1;
                out_stall_left <= draw_gap(out_calm_left);
            end
        end
    end

    // Watchdog: any handshake on either channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [XLEN-1:0]      base;
        logic [XLEN-1:0]      addr;
        logic [XLEN-1:0]      stored_addrs [$];
        logic [REG_IDX_W-1:0] base_reg;
        logic [REG_IDX_W-1:0] rd;
        logic [CMD_W-1:0]     cmd;
        int unsigned          roll;

        // Architectural state after reset: everything zero, memory included.
        for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
        for (int i = 0; i < MEM_DEPTH; i++) data_mem[i] = '0;
        arch_pc    = '0;
        retire_cnt = '0;

        // Directed opening: operand extremes, shift counts above five bits, writes to x0,
        // the last memory word with unaligned low bits, faults just past the end and at the top of
        // the address space, a load whose address wraps back into range, unsupported codes at
        // both ends, taken and untaken branches, and jalr with an odd target and with the
        // link register equal to the source.
        queue_instr(CMD_LUI,   5'd1,  5'd0,  5'd0,  32'h8000_0000);
        queue_instr(CMD_ADDI,  5'd2,  5'd0,  5'd0,  32'hFFFF_FFFF);
        queue_instr(CMD_ADDI,  5'd3,  5'd0,  5'd0,  32'h7FFF_FFFF);
        queue_instr(CMD_SRA,   5'd4,  5'd1,  5'd2,  32'd0);
        queue_instr(CMD_SRAI,  5'd5,  5'd1,  5'd0,  32'd33);
        queue_instr(CMD_SLT,   5'd6,  5'd1,  5'd3,  32'd0);
        queue_instr(CMD_SLTU,  5'd7,  5'd1,  5'd3,  32'd0);
        queue_instr(CMD_ADD,   5'd0,  5'd2,  5'd2,  32'd0);
        queue_instr(CMD_SW,    5'd9,  5'd0,  5'd2,  MEM_DEPTH * 4 - 1);
        queue_instr(CMD_LW,    5'd8,  5'd0,  5'd0,  MEM_DEPTH * 4 - 4);
        queue_instr(CMD_LW,    5'd9,  5'd0,  5'd0,  MEM_DEPTH * 4);
        queue_instr(CMD_SW,    5'd0,  5'd2,  5'd3,  32'd0);
        queue_instr(CMD_LW,    5'd10, 5'd2,  5'd0,  32'd5);
        queue_instr(CMD_UNSUP_LO, 5'd11, 5'd1, 5'd2, 32'd4);
        queue_instr(CMD_UNSUP_HI, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);
        queue_instr(CMD_BEQ,   5'd0,  5'd0,  5'd0,  32'h7FFF_FFFC);
        queue_instr(CMD_BLT,   5'd0,  5'd1,  5'd3,  -32'sd16);
        queue_instr(CMD_BGEU,  5'd0,  5'd1,  5'd3,  32'd8);
        queue_instr(CMD_BNE,   5'd0,  5'd2,  5'd2,  32'd100);
        queue_instr(CMD_JAL,   5'd11, 5'd0,  5'd0,  -32'sd4);
        queue_instr(CMD_JALR,  5'd12, 5'd12, 5'd0,  32'd7);
        queue_instr(CMD_JALR,  5'd13, 5'd2,  5'd0,  32'd0);
        queue_instr(CMD_AUIPC, 5'd14, 5'd0,  5'd0,  32'hFFFF_F000);
        queue_instr(CMD_SLL,   5'd15, 5'd2,  5'd3,  32'd0);
        queue_instr(CMD_NOP,   5'd16, 5'd1,  5'd2,  32'hFFFF_FFFF);

        // Random part. Most memory traffic comes as a short program: set a base register to
        // an arbitrary value, then stores and loads whose offsets land inside the memory,
        // often at addresses stored to a little earlier so that loads return real data.
        items_total = instr_pending.size() + RANDOM_ITEMS;
        while (instr_pending.size() < items_total) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                do cmd = CMD_W'($urandom_range(CMD_NOP, CMD_AUIPC));
                while (cmd == CMD_LW || cmd == CMD_SW);
                queue_instr(cmd, REG_IDX_W'($urandom), REG_IDX_W'($urandom),
                            REG_IDX_W'($urandom), pick_imm());
            end else if (roll < 85) begin
                base_reg = REG_IDX_W'($urandom_range(1, REG_COUNT - 1));
                base     = $urandom;
                queue_instr(CMD_ADDI, base_reg, 5'd0, REG_IDX_W'($urandom), base);
                repeat ($urandom_range(1, 4)) begin
                    if (stored_addrs.size() != 0 && $urandom_range(0, 1) == 1) begin
                        addr = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
                    end else begin
                        addr = $urandom_range(0, MEM_DEPTH * 4 - 1);
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        queue_instr(CMD_SW, REG_IDX_W'($urandom), base_reg,
                                    REG_IDX_W'($urandom), addr - base);
                        stored_addrs.push_back(addr);
                        if (stored_addrs.size() > 16) void'(stored_addrs.pop_front());
                    end else begin
                        // Keep the base intact for the rest of this sequence.
                        do rd = REG_IDX_W'($urandom);
                        while (rd == base_reg);
                        queue_instr(CMD_LW, rd, base_reg, REG_IDX_W'($urandom),
                                    addr - base);
                    end
                end
            end else if (roll < 93) begin
                // Loads and stores at arbitrary addresses, mostly faulting.
                cmd = ($urandom_range(0, 1) == 1) ? CMD_LW : CMD_SW;
                queue_instr(cmd, REG_IDX_W'($urandom), REG_IDX_W'($urandom),
                            REG_IDX_W'($urandom), pick_imm());
            end else begin
                queue_instr(CMD_W'($urandom_range(CMD_UNSUP_LO, CMD_UNSUP_HI)),
                            REG_IDX_W'($urandom), REG_IDX_W'($urandom),
                            REG_IDX_W'($urandom), $urandom);
            end
        end
        items_total = instr_pending.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_accepted < items_total || commit_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
design/rvexc_pkg.sv
design/rvexc_ram.sv
design/rv32i_execute_commit_core.sv
tb/sv/tb_rv32i_execute_commit_core.sv
